// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the md5 core and digest engine rtl files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/md5_pkg.sv =====
// md5 shared types, constants and tables
// no dependencies
package md5_pkg;

    localparam int MD5_WORD_W    = 32;
    localparam int MD5_BLK_WORDS = 16;
    localparam int MD5_ADDR_W    = $clog2(MD5_BLK_WORDS);

    localparam logic [1:0] RND_F = 2'd0;
    localparam logic [1:0] RND_G = 2'd1;
    localparam logic [1:0] RND_H = 2'd2;
    localparam logic [1:0] RND_I = 2'd3;

    localparam logic [5:0] LAST_ROUND = 6'd63;

    // word a sits in entry 0
    localparam logic [3:0][31:0] MD5_IV = {
        32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] MD5_K [64] = '{
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };

    localparam logic [4:0] MD5_ROT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic start;
        logic reinit;
    } md5_cmd_t;

    typedef struct packed {
        logic idle;
        logic done;
    } md5_stat_t;

    // message word index used by round r
    function automatic logic [3:0] md5_msg_idx(input logic [5:0] r);
        logic [3:0] lo;
        logic [3:0] q;
        begin
            lo = r[3:0];
            case (r[5:4])
                RND_F:   q = lo;
                RND_G:   q = (lo << 2) + lo + 4'd1;
                RND_H:   q = (lo << 1) + lo + 4'd5;
                RND_I:   q = (lo << 3) - lo;
                default: q = lo;
            endcase
            return q;
        end
    endfunction

endpackage

// ===== rtl/core/md5_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/md5_core.sv =====
// md5 compression unit: one round per cycle over a shared adder and rotator
// depends on md5_pkg and assert_macros.svh; reads message words from md5_ram
`include "assert_macros.svh"

module md5_core
    import md5_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  md5_cmd_t              cmd,
    output md5_stat_t             stat,
    output logic [MD5_ADDR_W-1:0] rd_addr,
    input  logic [MD5_WORD_W-1:0] rd_data,
    output logic [3:0][31:0]      chain
);

    typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} cstate_t;

    cstate_t     state_reg, state_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [3:0][31:0] chain_reg, chain_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;

    logic [31:0] f_val;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [4:0]  rot_amt;
    logic [5:0]  rnd_inc;

    assign rnd_inc = rnd_reg + 6'd1;
    assign rd_addr = (state_reg == C_ROUND) ? md5_msg_idx(rnd_inc) : md5_msg_idx(6'd0);

    always_comb
    begin
        case (rnd_reg[5:4])
            RND_F:   f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            RND_G:   f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            RND_H:   f_val = b_reg ^ c_reg ^ d_reg;
            RND_I:   f_val = c_reg ^ (b_reg | ~d_reg);
            default: f_val = b_reg ^ c_reg ^ d_reg;
        endcase
    end

    assign sum      = a_reg + f_val + rd_data + MD5_K[rnd_reg];
    assign rot_amt  = MD5_ROT[{rnd_reg[5:4], rnd_reg[1:0]}];
    assign rot_wide = {sum, sum} << rot_amt;

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        chain_next = chain_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = C_ROUND;
                    rnd_next   = 6'd0;
                    a_next     = chain_reg[0];
                    b_next     = chain_reg[1];
                    c_next     = chain_reg[2];
                    d_next     = chain_reg[3];
                end
                else if (cmd.reinit)
                begin
                    chain_next = MD5_IV;
                end
            end
            C_ROUND:
            begin
                a_next   = d_reg;
                d_next   = c_reg;
                c_next   = b_reg;
                b_next   = b_reg + rot_wide[63:32];
                rnd_next = rnd_inc;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = C_ADD;
                end
            end
            C_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                state_next    = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= 6'd0;
            chain_reg <= MD5_IV;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
    end

    assign stat.idle = (state_reg == C_IDLE);
    assign stat.done = (state_reg == C_ADD);
    assign chain     = chain_reg;

    `ASSERT_NEXT(a_start_runs, clk, rst_n, cmd.start && state_reg == C_IDLE, state_reg == C_ROUND && rnd_reg == 6'd0)
    `ASSERT_NEXT(a_last_round, clk, rst_n, state_reg == C_ROUND && rnd_reg == LAST_ROUND, state_reg == C_ADD)
    `ASSERT_IMP(a_idle_rnd_zero, clk, rst_n, state_reg == C_IDLE, rnd_reg == 6'd0)

endmodule

// ===== rtl/core/md5_digest_engine.sv =====
// md5 digest engine top level: byte intake, padding, digest output
// depends on md5_pkg, md5_ram, md5_core and assert_macros.svh
// processing: a byte that does not fill a block is stored; a byte that fills one starts a hash
// (64 rounds of the shared round unit and one chaining add)
// finishing: up to 72 padding bytes and one or two blocks, then 16 digest bytes
// intake: no byte is taken while a block is hashed, padded or output; the single round unit is the bound
// reset: asynchronous active low; initial vector loaded, bit count cleared, block buffer left as is
`include "assert_macros.svh"

module md5_digest_engine
    import md5_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] msg_byte,
    input  logic       byte_present,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] digest_byte,
    output logic [3:0] byte_index,
    output logic       last_byte
);

    typedef enum logic [1:0] {S_IDLE, S_HASH, S_PAD, S_OUT} state_t;

    state_t      state_reg, state_next;
    logic [60:0] byte_cnt_reg, byte_cnt_next;
    logic        end_pend_reg, end_pend_next;
    logic        pad_first_reg, pad_first_next;
    logic        len_phase_reg, len_phase_next;
    logic [3:0]  out_idx_reg, out_idx_next;
    logic [60:0] len_reg, len_next;
    logic [23:0] acc_reg, acc_next;

    logic        in_fire, out_fire;
    logic [5:0]  pos;
    logic        push_en;
    logic [7:0]  push_val;
    logic [63:0] len_bits;
    logic        blk_full;

    md5_cmd_t    cmd;
    md5_stat_t   stat;
    logic [MD5_ADDR_W-1:0] rd_addr;
    logic [MD5_WORD_W-1:0] rd_data;
    logic [3:0][31:0]      chain;
    logic        ram_wr_en;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign pos       = byte_cnt_reg[5:0];
    assign len_bits  = {len_reg, 3'b000};

    always_comb
    begin
        push_en  = 1'b0;
        push_val = 8'h00;
        case (state_reg)
            S_IDLE:
            begin
                push_en  = in_fire && byte_present;
                push_val = msg_byte;
            end
            S_PAD:
            begin
                push_en = 1'b1;
                if (pad_first_reg)
                begin
                    push_val = 8'h80;
                end
                else if (len_phase_reg || pos == 6'd56)
                begin
                    push_val = len_bits[{pos[2:0], 3'b000} +: 8];
                end
                else
                begin
                    push_val = 8'h00;
                end
            end
            default:
            begin
                push_en  = 1'b0;
                push_val = 8'h00;
            end
        endcase
    end

    assign blk_full  = push_en && (pos == 6'd63);
    assign ram_wr_en = push_en && (pos[1:0] == 2'b11);

    always_comb
    begin
        acc_next = acc_reg;
        if (push_en)
        begin
            case (pos[1:0])
                2'd0:    acc_next[7:0]   = push_val;
                2'd1:    acc_next[15:8]  = push_val;
                2'd2:    acc_next[23:16] = push_val;
                default: acc_next        = acc_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        byte_cnt_next  = byte_cnt_reg;
        end_pend_next  = end_pend_reg;
        pad_first_next = pad_first_reg;
        len_phase_next = len_phase_reg;
        out_idx_next   = out_idx_reg;
        len_next       = len_reg;
        cmd.start      = blk_full;
        cmd.reinit     = 1'b0;
        if (push_en)
        begin
            byte_cnt_next = byte_cnt_reg + 61'd1;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    end_pend_next  = end_of_message;
                    pad_first_next = end_of_message;
                    len_phase_next = 1'b0;
                    if (blk_full)
                    begin
                        state_next = S_HASH;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                pad_first_next = 1'b0;
                if (pad_first_reg)
                begin
                    len_next = byte_cnt_reg;
                end
                else if (pos == 6'd56)
                begin
                    len_phase_next = 1'b1;
                end
                if (blk_full)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (stat.done)
                begin
                    if (!end_pend_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (len_phase_reg)
                    begin
                        state_next   = S_OUT;
                        out_idx_next = 4'd0;
                    end
                    else
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    out_idx_next = out_idx_reg + 4'd1;
                    if (out_idx_reg == 4'd15)
                    begin
                        state_next     = S_IDLE;
                        byte_cnt_next  = 61'd0;
                        end_pend_next  = 1'b0;
                        len_phase_next = 1'b0;
                        cmd.reinit     = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            byte_cnt_reg  <= 61'd0;
            end_pend_reg  <= 1'b0;
            pad_first_reg <= 1'b0;
            len_phase_reg <= 1'b0;
            out_idx_reg   <= 4'd0;
        end
        else
        begin
            state_reg     <= state_next;
            byte_cnt_reg  <= byte_cnt_next;
            end_pend_reg  <= end_pend_next;
            pad_first_reg <= pad_first_next;
            len_phase_reg <= len_phase_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        acc_reg <= acc_next;
    end

    md5_ram #(
        .WIDTH (MD5_WORD_W),
        .DEPTH (MD5_BLK_WORDS)
    ) u_buf (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos[5:2]),
        .wr_data ({push_val, acc_reg}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    md5_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .chain   (chain)
    );

    assign digest_byte = chain[out_idx_reg[3:2]][{out_idx_reg[1:0], 3'b000} +: 8];
    assign byte_index  = out_idx_reg;
    assign last_byte   = (out_idx_reg == 4'd15);

    `ASSERT_IMP(a_wr_core_idle, clk, rst_n, ram_wr_en, stat.idle)
    `ASSERT_IMP(a_hash_core_busy, clk, rst_n, state_reg == S_HASH, !stat.idle)
    `ASSERT_NEXT(a_finish_clears, clk, rst_n, out_fire && last_byte, state_reg == S_IDLE && byte_cnt_reg == 61'd0)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for md5_digest_engine: random and directed byte streams
// with an internal md5 predictor and an in-order digest word scoreboard
// depends only on the md5_digest_engine rtl and its package
module tb;

    localparam int HOLD_CYCLES = 600;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 12;

    localparam bit [31:0] SINE [64] = '{
        32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
        32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
        32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
        32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
        32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
        32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
        32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
        32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
        32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
        32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
        32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
        32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
        32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
        32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
        32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
        32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
    };

    localparam int SHIFTS [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    localparam bit [31:0] START_VEC [4] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476
    };

    class md5_digest_tracker;

        typedef struct {
            bit [7:0] digest_byte;
            bit [3:0] byte_index;
            bit       last_byte;
        } digest_word_t;

        bit [31:0]    chain [4];
        bit [7:0]     blk [64];
        bit [63:0]    nbits;
        digest_word_t digest_due [$];
        int           errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 4; i++)
            begin
                chain[i] = START_VEC[i];
            end
            nbits = '0;
        endfunction

        function void compress();
            bit [31:0] w [16];
            bit [31:0] a, b, c, d, f, t;
            int        g, s;
            for (int i = 0; i < 16; i++)
            begin
                w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
            end
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            for (int i = 0; i < 64; i++)
            begin
                case (i / 16)
                    0:
                    begin
                        f = (b & c) | (~b & d);
                        g = i;
                    end
                    1:
                    begin
                        f = (b & d) | (c & ~d);
                        g = (5 * i + 1) % 16;
                    end
                    2:
                    begin
                        f = b ^ c ^ d;
                        g = (3 * i + 5) % 16;
                    end
                    default:
                    begin
                        f = c ^ (b | ~d);
                        g = (7 * i) % 16;
                    end
                endcase
                t = a + f + w[g] + SINE[i];
                s = SHIFTS[(i / 16) * 4 + (i % 4)];
                a = d;
                d = c;
                c = b;
                b = b + ((t << s) | (t >> (32 - s)));
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
        endfunction

        function void absorb(bit [7:0] v);
            bit [5:0] pos;
            pos = nbits[8:3];
            blk[pos] = v;
            nbits += 64'd8;
            if (pos == 6'd63)
            begin
                compress();
            end
        endfunction

        function void take_word(bit [7:0] b, bit present, bit eom);
            bit [63:0]    msg_len;
            digest_word_t dw;
            if (present)
            begin
                absorb(b);
            end
            if (!eom)
            begin
                return;
            end
            msg_len = nbits;
            absorb(8'h80);
            while (nbits[8:3] != 6'd56)
            begin
                absorb(8'h00);
            end
            for (int i = 0; i < 8; i++)
            begin
                absorb(msg_len[8*i +: 8]);
            end
            for (int i = 0; i < 16; i++)
            begin
                dw.digest_byte = chain[i / 4][8*(i % 4) +: 8];
                dw.byte_index  = i[3:0];
                dw.last_byte   = (i == 15);
                digest_due.push_back(dw);
            end
            restart();
        endfunction

        function void check_word(bit [7:0] db, bit [3:0] idx, bit lb);
            digest_word_t dw;
            if (digest_due.size() == 0)
            begin
                $error("digest word with no expectation: byte %h index %0d", db, idx);
                errors++;
                return;
            end
            dw = digest_due.pop_front();
            if (db !== dw.digest_byte)
            begin
                $error("digest_byte: expected %h, actual %h", dw.digest_byte, db);
                errors++;
            end
            if (idx !== dw.byte_index)
            begin
                $error("byte_index: expected %0d, actual %0d", dw.byte_index, idx);
                errors++;
            end
            if (lb !== dw.last_byte)
            begin
                $error("last_byte: expected %0b, actual %0b", dw.last_byte, lb);
                errors++;
            end
        endfunction

    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] digest_byte;
    logic [3:0] byte_index;
    logic       last_byte;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles;
    bit  hold_req;

    md5_digest_tracker tracker = new();

    md5_digest_engine i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .msg_byte       (msg_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_byte    (digest_byte),
        .byte_index     (byte_index),
        .last_byte      (last_byte)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // accepted words on both sides, plus the no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                tracker.take_word(msg_byte, byte_present, end_of_message);
            end
            if (out_valid && out_ready)
            begin
                tracker.check_word(digest_byte, byte_index, last_byte);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // digest side back-pressure
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [7:0] b, input logic present, input logic eom);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        msg_byte       <= b;
        byte_present   <= present;
        end_of_message <= eom;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
    endtask

    // random message with optional empty words; the end rides on the last byte or stands alone
    task automatic send_message(input int len, input bit hold_at_end, inout int sent);
        bit joined;
        joined = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            if (hold_at_end && (i == len - 1))
            begin
                hold_req = 1'b1;
            end
            send_word(8'($urandom_range(0, 255)), 1'b1, joined && (i == len - 1));
            sent++;
        end
        if (!joined)
        begin
            if (hold_at_end && len == 0)
            begin
                hold_req = 1'b1;
            end
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            sent++;
        end
    endtask

    initial
    begin
        int sent;
        int len;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        msg_byte       = 8'h00;
        byte_present   = 1'b0;
        end_of_message = 1'b0;
        hold_req       = 1'b0;
        quiet_cycles   = 0;
        send_idle_pct  = 14;
        recv_idle_pct  = 50;
        sent           = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty message, twice back to back
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        // single zero byte, end alone
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        // single all-ones byte with end in the same word
        send_word(8'hFF, 1'b1, 1'b1);
        // "abc", end on the last byte
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        // empty words inside a message change nothing
        send_word(8'hA5, 1'b0, 1'b0);
        send_word(8'h55, 1'b1, 1'b0);
        send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'hAA, 1'b1, 1'b0);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 50 : 0;
            recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 14 : 0;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                // the first message of phase 1 has 55 to 65 bytes, around the pad boundary
                if (phase == 1 && sent == 0)
                begin
                    len = $urandom_range(55, 65);
                end
                else
                begin
                    len = $urandom_range(0, 12);
                end
                send_message(len, (phase == 2) && (sent == 0), sent);
            end
        end
        in_valid <= 1'b0;

        while (tracker.digest_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (tracker.errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
